// File: hw/rtl/region_lock_table_top_assert.svh
// assertion macros for the region lock table
`ifndef REGION_LOCK_TABLE_TOP_ASSERT_SVH
`define REGION_LOCK_TABLE_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RLT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define RLT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/rlt_pkg.sv
// shared types, constants and codes of the region lock table
package rlt_pkg;

   localparam int TABLE_ENTRIES_DEF = 16;
   localparam int REGION_BYTES_DEF  = 16;
   localparam int MAX_SPAN_DEF      = 16;

   localparam int OFFSET_W = 32;
   localparam int LEN_W    = 16;
   localparam int WHO_W    = 8;
   localparam int COUNT_W  = 8;
   localparam int STATUS_W = 3;

   // half-width reciprocal multiply steps per division
   localparam int DIV_STEPS = 2;

   localparam logic REQ_ACQUIRE = 1'b0;
   localparam logic REQ_RELEASE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_GRANTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_CONFLICT = 3'd1;
   localparam logic [STATUS_W-1:0] ST_REL_ERR  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NO_ROOM  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd4;

   typedef struct packed {
      logic                req_type;
      logic [OFFSET_W-1:0] range_start;
      logic [LEN_W-1:0]    range_length;
      logic [WHO_W-1:0]    requester;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                region_freed;
   } rsp_word_type;

   // controller to datapath
   typedef struct packed {
      logic                latch;
      logic                div_load;
      logic                div_step;
      logic                cur_load;
      logic                scan_step;
      logic                commit_step;
      logic                rel_step;
      logic                finish;
      logic [STATUS_W-1:0] rsp_status;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_release;
      logic zero_len;
      logic overflow;
      logic span_long;
      logic at_last;
      logic rel_ok;
      logic conflict_seen;
      logic nospace;
   } dp_status_type;

endpackage

// File: hw/rtl/rlt_div.sv
// divide by a constant through a reciprocal multiply, one dividend half per step
module rlt_div #(
   parameter int DIVISOR = rlt_pkg::REGION_BYTES_DEF
) (
   input  logic                         clock,
   input  logic                         load,
   input  logic                         step,
   input  logic [rlt_pkg::OFFSET_W-1:0] dividend,
   output logic [rlt_pkg::OFFSET_W-1:0] quotient
);
   import rlt_pkg::*;

   localparam int SHIFT = $clog2(DIVISOR);
   localparam int HW    = OFFSET_W / DIV_STEPS;
   localparam int MW    = OFFSET_W + 1;
   localparam int PW    = OFFSET_W + MW;
   // ceil(2^(OFFSET_W+SHIFT) / DIVISOR) gives the exact quotient for every dividend
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << (OFFSET_W + SHIFT)) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
   localparam logic [MW-1:0] RECIP = RECIP_FULL[MW-1:0];

   logic [PW-1:0]       acc_ff, acc_in;
   logic [OFFSET_W-1:0] dvd_ff, dvd_in;
   logic [HW+MW-1:0]    part;

   always_comb begin
      part   = (HW+MW)'(dvd_ff[OFFSET_W-1 -: HW]) * (HW+MW)'(RECIP);
      acc_in = acc_ff;
      dvd_in = dvd_ff;
      if (load) begin
         acc_in = '0;
         dvd_in = dividend;
      end else if (step) begin
         // high half first, the running sum moves up one half each step
         acc_in = {acc_ff[PW-HW-1:0], {HW{1'b0}}} + PW'(part);
         dvd_in = {dvd_ff[OFFSET_W-HW-1:0], {HW{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      dvd_ff <= dvd_in;
   end

   assign quotient = OFFSET_W'(acc_ff >> (OFFSET_W + SHIFT));

endmodule

// File: hw/rtl/rlt_datapath.sv
// request registers, region dividers, lock table and result register
module rlt_datapath #(
   parameter int TABLE_ENTRIES = rlt_pkg::TABLE_ENTRIES_DEF,
   parameter int REGION_BYTES  = rlt_pkg::REGION_BYTES_DEF,
   parameter int MAX_SPAN      = rlt_pkg::MAX_SPAN_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rlt_pkg::req_word_type req_data,
   input  rlt_pkg::cmd_type      cmd,
   output rlt_pkg::dp_status_type stat,
   output logic                  rsp_strobe,
   output rlt_pkg::rsp_word_type rsp_data
);
   import rlt_pkg::*;

   localparam int RW = $clog2((64'hFFFF_FFFF / REGION_BYTES) + 1);
   localparam int UW = $clog2(TABLE_ENTRIES + 1);
   localparam int MW = $clog2(MAX_SPAN + 1);

   req_word_type        req_ff;
   logic [OFFSET_W:0]   end_sum;
   logic [OFFSET_W-1:0] quo_first, quo_last;
   logic [RW-1:0]       first, last, span_diff;

   logic [RW-1:0] cur_ff, cur_in;
   logic          conf_ff, conf_in;
   logic          sat_ff, sat_in;
   logic [MW-1:0] miss_ff, miss_in;
   logic          freed_ff, freed_in;
   logic [UW-1:0] used_ff, used_in;

   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [RW-1:0]            region_ff [TABLE_ENTRIES];
   logic [RW-1:0]            region_in [TABLE_ENTRIES];
   logic [WHO_W-1:0]         owner_ff  [TABLE_ENTRIES];
   logic [WHO_W-1:0]         owner_in  [TABLE_ENTRIES];
   logic [COUNT_W-1:0]       count_ff  [TABLE_ENTRIES];
   logic [COUNT_W-1:0]       count_in  [TABLE_ENTRIES];

   logic [TABLE_ENTRIES-1:0] match, own, live, full_cnt, last_ref;
   logic [TABLE_ENTRIES-1:0] not_valid, free_oh;
   logic hit, conflict_hit, sat_hit, rel_ok, frees_now;

   logic         rsp_strobe_ff;
   rsp_word_type rsp_data_ff;

   assign end_sum = {1'b0, req_ff.range_start} + (OFFSET_W+1)'(req_ff.range_length)
                    - (OFFSET_W+1)'(1);

   rlt_div #(.DIVISOR(REGION_BYTES)) u_div_first (
      .clock    (clock),
      .load     (cmd.div_load),
      .step     (cmd.div_step),
      .dividend (req_ff.range_start),
      .quotient (quo_first)
   );

   rlt_div #(.DIVISOR(REGION_BYTES)) u_div_last (
      .clock    (clock),
      .load     (cmd.div_load),
      .step     (cmd.div_step),
      .dividend (end_sum[OFFSET_W-1:0]),
      .quotient (quo_last)
   );

   assign first     = quo_first[RW-1:0];
   assign last      = quo_last[RW-1:0];
   assign span_diff = last - first;

   // each entry compares against the current region in its own lane
   always_comb begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         match[i]    = valid_ff[i] && (region_ff[i] == cur_ff);
         own[i]      = owner_ff[i] == req_ff.requester;
         live[i]     = count_ff[i] != '0;
         full_cnt[i] = count_ff[i] == {COUNT_W{1'b1}};
         last_ref[i] = count_ff[i] == COUNT_W'(1);
      end
   end

   assign hit          = |match;
   assign conflict_hit = |(match & ~own & live);
   assign sat_hit      = |(match & full_cnt);
   assign rel_ok       = |(match & own & live);
   assign frees_now    = |(match & last_ref);

   // lowest free slot as a one-hot vector
   assign not_valid = ~valid_ff;
   assign free_oh   = not_valid & (~not_valid + TABLE_ENTRIES'(1));

   always_comb begin
      valid_in  = valid_ff;
      region_in = region_ff;
      owner_in  = owner_ff;
      count_in  = count_ff;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (cmd.commit_step) begin
            if (match[i]) begin
               count_in[i] = count_ff[i] + COUNT_W'(1);
               owner_in[i] = req_ff.requester;
            end else if (!hit && free_oh[i]) begin
               valid_in[i]  = 1'b1;
               region_in[i] = cur_ff;
               owner_in[i]  = req_ff.requester;
               count_in[i]  = COUNT_W'(1);
            end
         end
         if (cmd.rel_step && match[i]) begin
            count_in[i] = count_ff[i] - COUNT_W'(1);
            if (last_ref[i]) begin
               valid_in[i] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      used_in = used_ff;
      if (cmd.commit_step && !hit) begin
         used_in = used_ff + UW'(1);
      end else if (cmd.rel_step && frees_now) begin
         used_in = used_ff - UW'(1);
      end

      cur_in = cur_ff;
      if (cmd.cur_load) begin
         cur_in = first;
      end else if (cmd.scan_step || cmd.commit_step || cmd.rel_step) begin
         cur_in = cur_ff + RW'(1);
      end

      conf_in = conf_ff;
      sat_in  = sat_ff;
      miss_in = miss_ff;
      if (cmd.cur_load) begin
         conf_in = 1'b0;
         sat_in  = 1'b0;
         miss_in = '0;
      end else if (cmd.scan_step) begin
         conf_in = conf_ff | conflict_hit;
         sat_in  = sat_ff | sat_hit;
         if (!hit) begin
            miss_in = miss_ff + MW'(1);
         end
      end

      freed_in = freed_ff;
      if (cmd.latch) begin
         freed_in = 1'b0;
      end else if (cmd.rel_step && frees_now) begin
         freed_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         used_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         used_ff       <= used_in;
         rsp_strobe_ff <= cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         req_ff <= req_data;
      end
      region_ff <= region_in;
      owner_ff  <= owner_in;
      count_ff  <= count_in;
      cur_ff    <= cur_in;
      conf_ff   <= conf_in;
      sat_ff    <= sat_in;
      miss_ff   <= miss_in;
      freed_ff  <= freed_in;
      if (cmd.finish) begin
         rsp_data_ff.status       <= cmd.rsp_status;
         rsp_data_ff.region_freed <= freed_in;
      end
   end

   always_comb begin
      stat.is_release    = req_ff.req_type == REQ_RELEASE;
      stat.zero_len      = req_ff.range_length == '0;
      stat.overflow      = end_sum[OFFSET_W];
      stat.span_long     = 32'(span_diff) >= 32'(MAX_SPAN);
      stat.at_last       = cur_ff == last;
      stat.rel_ok        = rel_ok;
      stat.conflict_seen = conf_ff;
      stat.nospace       = sat_ff || ((32'(used_ff) + 32'(miss_ff)) > 32'(TABLE_ENTRIES));
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// File: hw/rtl/rlt_ctrl.sv
// sequencing state machine of the region lock table
module rlt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  rlt_pkg::dp_status_type stat,
   output rlt_pkg::cmd_type       cmd
);
   import rlt_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_PREP   = 3'd1;
   localparam logic [2:0] S_DIV    = 3'd2;
   localparam logic [2:0] S_SPAN   = 3'd3;
   localparam logic [2:0] S_SCAN   = 3'd4;
   localparam logic [2:0] S_DECIDE = 3'd5;
   localparam logic [2:0] S_COMMIT = 3'd6;
   localparam logic [2:0] S_REL    = 3'd7;

   localparam int CW = $clog2(DIV_STEPS);

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] div_cnt_ff, div_cnt_in;

   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = S_PREP;
            end
         end
         S_PREP: begin
            if (stat.zero_len) begin
               cmd.finish     = 1'b1;
               cmd.rsp_status = ST_GRANTED;
               state_in       = S_IDLE;
            end else if (stat.overflow) begin
               cmd.finish     = 1'b1;
               cmd.rsp_status = ST_TOO_LONG;
               state_in       = S_IDLE;
            end else begin
               cmd.div_load = 1'b1;
               div_cnt_in   = '0;
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + CW'(1);
            if (div_cnt_ff == CW'(DIV_STEPS - 1)) begin
               state_in = S_SPAN;
            end
         end
         S_SPAN: begin
            if (stat.span_long) begin
               cmd.finish     = 1'b1;
               cmd.rsp_status = ST_TOO_LONG;
               state_in       = S_IDLE;
            end else begin
               cmd.cur_load = 1'b1;
               state_in     = stat.is_release ? S_REL : S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.at_last) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            // conflict wins over lack of room anywhere in the range
            if (stat.conflict_seen) begin
               cmd.finish     = 1'b1;
               cmd.rsp_status = ST_CONFLICT;
               state_in       = S_IDLE;
            end else if (stat.nospace) begin
               cmd.finish     = 1'b1;
               cmd.rsp_status = ST_NO_ROOM;
               state_in       = S_IDLE;
            end else begin
               cmd.cur_load = 1'b1;
               state_in     = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.commit_step = 1'b1;
            if (stat.at_last) begin
               cmd.finish     = 1'b1;
               cmd.rsp_status = ST_GRANTED;
               state_in       = S_IDLE;
            end
         end
         S_REL: begin
            if (!stat.rel_ok) begin
               cmd.finish     = 1'b1;
               cmd.rsp_status = ST_REL_ERR;
               state_in       = S_IDLE;
            end else begin
               cmd.rel_step = 1'b1;
               if (stat.at_last) begin
                  cmd.finish     = 1'b1;
                  cmd.rsp_status = ST_GRANTED;
                  state_in       = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   assign busy = state_ff != S_IDLE;

endmodule

// File: hw/rtl/region_lock_table_top.sv
// top level of the region lock table
//
// A request word (acquire or release of a byte range by one requester) is taken
// on req_data at a clock edge where start is high and busy is low. busy then
// stays high until the request is decided. Exactly one result word per request
// appears on rsp_data, marked by rsp_strobe for a single cycle, in the first
// cycle with busy low again; the receiver cannot hold it off and must take it then.
// Outcomes by request: a zero length or a range past the offset space is decided
// before the dividers run; a span wider than MAX_SPAN is refused once they are
// through; an acquire then takes one scan pass, and a second, commit pass only
// when granted (a conflict or lack of room ends it after the scan); a release
// takes one pass and stops early at a bad region. The region dividers work one
// half-width reciprocal multiply per step; each pass costs one table match per
// region. A new request may be accepted during the result cycle.
// Reset empties the table at once; there is no clearing pass.
`include "region_lock_table_top_assert.svh"

module region_lock_table_top #(
   parameter int TABLE_ENTRIES = rlt_pkg::TABLE_ENTRIES_DEF,
   parameter int REGION_BYTES  = rlt_pkg::REGION_BYTES_DEF,
   parameter int MAX_SPAN      = rlt_pkg::MAX_SPAN_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  rlt_pkg::req_word_type req_data,
   output logic                  rsp_strobe,
   output rlt_pkg::rsp_word_type rsp_data
);
   import rlt_pkg::*;

   cmd_type       cmd;
   dp_status_type stat;

   rlt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   rlt_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .REGION_BYTES  (REGION_BYTES),
      .MAX_SPAN      (MAX_SPAN)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   `RLT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
   `RLT_ASSERT_NEXT(a_finish_strobe, cmd.finish, rsp_strobe && !busy, "finish gave no result")
   `RLT_ASSERT_NOW(a_strobe_idle, rsp_strobe, !$past(cmd.finish) == 1'b0, "stray result strobe")
   `RLT_ASSERT_NOW(a_one_step, 1'b1,
      $onehot0({cmd.div_step, cmd.scan_step, cmd.commit_step, cmd.rel_step}),
      "two datapath steps at once")

endmodule

// File: dv/region_lock_table_top_test.sv
// self-checking testbench for the region lock table: directed and random lock traffic
`timescale 1ns / 1ps

module region_lock_table_top_test;
   import rlt_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 80;

   typedef struct {
      req_word_type word;
      bit           drain;
   } pending_item_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   req_word_type req_data = '0;
   logic         busy;
   logic         rsp_strobe;
   rsp_word_type rsp_data;

   pending_item_type pending_q[$];
   rsp_word_type     lock_expect_q[$];
   req_word_type     held_ranges[$];

   // shadow lock table
   bit          lock_valid[TABLE_ENTRIES_DEF];
   int unsigned lock_region[TABLE_ENTRIES_DEF];
   logic [7:0]  lock_owner[TABLE_ENTRIES_DEF];
   logic [7:0]  lock_count[TABLE_ENTRIES_DEF];

   int          mismatch_count = 0;
   int          cycle_count = 0;
   bit          word_taken = 1'b0;
   bit          idle_now;
   logic [31:0] hot_base;
   logic [7:0]  crew[4];

   region_lock_table_top uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #4 clock = ~clock;

   function automatic int slot_of(int unsigned rg);
      for (int k = 0; k < TABLE_ENTRIES_DEF; k++) begin
         if (lock_valid[k] && lock_region[k] == rg) return k;
      end
      return -1;
   endfunction

   // expected result of one request; updates the shadow table
   function automatic rsp_word_type lock_outcome(req_word_type w);
      rsp_word_type res;
      logic [32:0]  last_byte;
      int unsigned  first_rg, last_rg, rg;
      int           k, missing, frees;
      res.status = ST_GRANTED;
      res.region_freed = 1'b0;
      if (w.range_length == '0) return res;
      last_byte = {1'b0, w.range_start} + 33'(w.range_length) - 33'd1;
      if (last_byte[32]) begin
         res.status = ST_TOO_LONG;
         return res;
      end
      first_rg = w.range_start / REGION_BYTES_DEF;
      last_rg = last_byte[31:0] / REGION_BYTES_DEF;
      if (last_rg - first_rg >= MAX_SPAN_DEF) begin
         res.status = ST_TOO_LONG;
         return res;
      end
      if (w.req_type == REQ_ACQUIRE) begin
         for (rg = first_rg; rg <= last_rg; rg++) begin
            k = slot_of(rg);
            if (k >= 0 && lock_owner[k] != w.requester) begin
               res.status = ST_CONFLICT;
               return res;
            end
         end
         missing = 0;
         for (rg = first_rg; rg <= last_rg; rg++) begin
            k = slot_of(rg);
            if (k < 0) missing++;
            else if (lock_count[k] == 8'hFF) begin
               res.status = ST_NO_ROOM;
               return res;
            end
         end
         frees = 0;
         for (int j = 0; j < TABLE_ENTRIES_DEF; j++) if (!lock_valid[j]) frees++;
         if (missing > frees) begin
            res.status = ST_NO_ROOM;
            return res;
         end
         for (rg = first_rg; rg <= last_rg; rg++) begin
            k = slot_of(rg);
            if (k < 0) begin
               // lowest free slot
               for (int j = TABLE_ENTRIES_DEF - 1; j >= 0; j--) if (!lock_valid[j]) k = j;
               lock_valid[k] = 1'b1;
               lock_region[k] = rg;
               lock_count[k] = 8'd1;
            end else begin
               lock_count[k] = lock_count[k] + 8'd1;
            end
            lock_owner[k] = w.requester;
         end
      end else begin
         for (rg = first_rg; rg <= last_rg; rg++) begin
            k = slot_of(rg);
            if (k < 0 || lock_owner[k] != w.requester || lock_count[k] == 8'd0) begin
               res.status = ST_REL_ERR;
               return res;
            end
            lock_count[k] = lock_count[k] - 8'd1;
            if (lock_count[k] == 8'd0) begin
               lock_valid[k] = 1'b0;
               res.region_freed = 1'b1;
            end
         end
      end
      return res;
   endfunction

   function automatic void note_mismatch(string msg);
      if (mismatch_count < 10) $display("%s", msg);
      mismatch_count++;
   endfunction

   task automatic queue_req(logic kind, logic [31:0] at, logic [15:0] len, logic [7:0] who);
      pending_item_type it;
      it.word.req_type = kind;
      it.word.range_start = at;
      it.word.range_length = len;
      it.word.requester = who;
      it.drain = 1'b0;
      pending_q = {pending_q, it};
   endtask

   // hold the sender until every outstanding word has been answered
   task automatic queue_drain();
      pending_item_type it;
      it.word = '0;
      it.drain = 1'b1;
      pending_q = {pending_q, it};
   endtask

   // mostly acquire/release pairs in a shared window, some noise and broken releases
   task automatic queue_mixed_req();
      req_word_type w;
      int           pick, idx;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         w.req_type = 1'($urandom_range(0, 1));
         w.range_start = $urandom;
         w.range_length = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                               : 16'($urandom_range(0, 300));
         w.requester = 8'($urandom_range(0, 255));
         if (w.req_type == REQ_ACQUIRE && w.range_length <= 300) held_ranges = {held_ranges, w};
      end else if (held_ranges.size() > 0 && (pick < 50 || held_ranges.size() > 6)) begin
         idx = $urandom_range(0, held_ranges.size() - 1);
         w = held_ranges[idx];
         w.req_type = REQ_RELEASE;
         if ($urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 1)) w.requester = w.requester ^ (8'h1 << $urandom_range(0, 7));
            else w.range_start = w.range_start + 32'd16;
         end else begin
            held_ranges.delete(idx);
         end
      end else if (held_ranges.size() > 0 && pick < 62) begin
         // recursive acquire of a range already asked for
         w = held_ranges[$urandom_range(0, held_ranges.size() - 1)];
         w.req_type = REQ_ACQUIRE;
         held_ranges = {held_ranges, w};
      end else begin
         w.req_type = REQ_ACQUIRE;
         w.range_start = hot_base + $urandom_range(0, 511);
         w.range_length = 16'($urandom_range(1, 64));
         w.requester = crew[$urandom_range(0, 3)];
         held_ranges = {held_ranges, w};
      end
      queue_req(w.req_type, w.range_start, w.range_length, w.requester);
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (word_taken) void'(pending_q.pop_front());
         idle_now = (cycle_count % 10000) >= 2500 && $urandom_range(0, 99) < 23;
         if (pending_q.size() == 0) begin
            start <= 1'b0;
         end else if (pending_q[0].drain) begin
            start <= 1'b0;
            if (lock_expect_q.size() == 0 && !busy) void'(pending_q.pop_front());
         end else begin
            start <= !idle_now;
            req_data <= pending_q[0].word;
         end
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      rsp_word_type want;
      word_taken <= !reset && start && !busy;
      if (!reset && rsp_strobe) begin
         if (lock_expect_q.size() == 0) begin
            note_mismatch($sformatf("unexpected result word: status %0d freed %0b",
                                    rsp_data.status, rsp_data.region_freed));
         end else begin
            want = lock_expect_q.pop_front();
            if (rsp_data.status !== want.status)
               note_mismatch($sformatf("status: expected %0d, got %0d",
                                       want.status, rsp_data.status));
            if (rsp_data.region_freed !== want.region_freed)
               note_mismatch($sformatf("region_freed: expected %0b, got %0b",
                                       want.region_freed, rsp_data.region_freed));
         end
      end
      if (!reset && start && !busy) lock_expect_q = {lock_expect_q, lock_outcome(req_data)};
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      logic [31:0] burst_at;
      logic [7:0]  burst_who;
      for (int k = 0; k < TABLE_ENTRIES_DEF; k++) begin
         lock_valid[k] = 1'b0;
         lock_region[k] = 0;
         lock_owner[k] = '0;
         lock_count[k] = '0;
      end
      hot_base = $urandom_range(0, 32'hFFFF_0000);
      for (int k = 0; k < 4; k++) crew[k] = 8'($urandom_range(0, 255));

      // directed part, starting from an empty table
      queue_req(REQ_ACQUIRE, 32'hFFFF_FFFF, 16'd0, 8'h00);    // zero length
      queue_req(REQ_RELEASE, 32'hFFFF_FFFF, 16'd0, 8'hFF);
      queue_req(REQ_ACQUIRE, 32'hFFFF_FFFF, 16'd1, 8'hFF);    // last byte of offset space
      queue_req(REQ_ACQUIRE, 32'hFFFF_FFFF, 16'd2, 8'hFF);    // runs past offset space
      queue_req(REQ_RELEASE, 32'hFFFF_FFFF, 16'd1, 8'h00);    // wrong owner
      queue_req(REQ_RELEASE, 32'hFFFF_FFFF, 16'd1, 8'hFF);    // frees it
      queue_req(REQ_ACQUIRE, 32'h0000_0000, 16'd256, 8'h01);  // full span fills the table
      queue_req(REQ_ACQUIRE, 32'h0000_0000, 16'd257, 8'h01);  // one region too wide
      queue_req(REQ_ACQUIRE, 32'h0000_1000, 16'd1, 8'h02);    // table full
      queue_req(REQ_ACQUIRE, 32'h0000_0010, 16'd1, 8'h02);    // held by another
      queue_req(REQ_ACQUIRE, 32'h0000_0000, 16'd16, 8'h01);   // recursive
      queue_req(REQ_RELEASE, 32'h0000_0000, 16'd256, 8'h01);
      queue_req(REQ_RELEASE, 32'h0000_0000, 16'd32, 8'h01);   // stops at missing region
      queue_req(REQ_ACQUIRE, 32'h0000_0020, 16'hFFFF, 8'h03);
      queue_req(REQ_ACQUIRE, 32'h0000_0000, 16'hFFFF, 8'h03);
      queue_req(REQ_RELEASE, 32'h0000_0100, 16'd1, 8'h04);    // never held
      queue_req(REQ_ACQUIRE, 32'h0000_0040, 16'd32, 8'h05);
      queue_req(REQ_RELEASE, 32'h0000_0040, 16'd48, 8'h05);
      queue_drain();

      repeat (150) queue_mixed_req();
      queue_drain();

      // drive one region's count to saturation
      burst_at = hot_base + 32'h2000 + $urandom_range(0, 15);
      burst_who = 8'($urandom_range(0, 255));
      repeat (256) queue_req(REQ_ACQUIRE, burst_at, 16'($urandom_range(1, 16 - burst_at[3:0])),
                             burst_who);
      queue_req(REQ_RELEASE, burst_at, 16'd1, burst_who ^ 8'h80);
      repeat (4) queue_req(REQ_RELEASE, burst_at, 16'd1, burst_who);
      queue_req(REQ_ACQUIRE, burst_at, 16'd1, burst_who ^ 8'h01);

      repeat (140) queue_mixed_req();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (pending_q.size() != 0 || lock_expect_q.size() != 0 || busy);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
